### sv/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check a consequence in the cycle after an unmasked condition, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/rbst_pkg.sv
// Package with shared constants and types of the 2D ray/box slab test.
package rbst_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Per-item flags that travel beside the divider lanes.
  typedef struct packed {
    logic zero_x;
    logic zero_y;
    logic ok_x;
    logic ok_y;
  } side_flags_t;

endpackage

### sv/ray_box_slab_test_2d.sv
// Top level of the 2D ray versus axis-aligned box slab test.
// Throughput: one transaction per cycle while in_stall is low; four divider lanes each run one
// restoring step per pipeline stage, so a new item enters every cycle unless the pipeline holds.
// The whole pipeline holds only while a finished result waits under out_stall.
// Reset (rst, synchronous) clears all valid bits; payload registers keep garbage.
module ray_box_slab_test_2d #(
  parameter int WORD_WIDTH = rbst_pkg::WORD_WIDTH,
  parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [WORD_WIDTH-1:0] ray_origin_x,
  input  logic signed [WORD_WIDTH-1:0] ray_origin_y,
  input  logic signed [WORD_WIDTH-1:0] ray_dir_x,
  input  logic signed [WORD_WIDTH-1:0] ray_dir_y,
  input  logic signed [WORD_WIDTH-1:0] box_low_x,
  input  logic signed [WORD_WIDTH-1:0] box_low_y,
  input  logic signed [WORD_WIDTH-1:0] box_high_x,
  input  logic signed [WORD_WIDTH-1:0] box_high_y,
  input  logic signed [WORD_WIDTH-1:0] window_start,
  input  logic signed [WORD_WIDTH-1:0] window_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [WORD_WIDTH-1:0] t_enter,
  output logic signed [WORD_WIDTH-1:0] t_exit
);

`include "assert_macros.svh"

  localparam int W = WORD_WIDTH;
  // Divider stages plus the lane's clamp stage.
  localparam int D = WORD_WIDTH + 1 + FRAC_BITS + 1;

  // Advance everything unless the output register is full and held.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Slab setup for one axis: pick planes by direction sign, form |plane - origin|.
  logic [W:0]   nlo_x, nhi_x, nlo_y, nhi_y;
  logic [W-1:0] dmag_x, dmag_y;
  logic         neglo_x, neghi_x, neglo_y, neghi_y;
  rbst_pkg::side_flags_t flags_in;

  always_comb begin
    logic signed [W-1:0] plo, phi;
    logic signed [W:0]   dlo, dhi;
    // x axis
    plo     = ray_dir_x[W-1] ? box_high_x : box_low_x;
    phi     = ray_dir_x[W-1] ? box_low_x  : box_high_x;
    dlo     = {plo[W-1], plo} - {ray_origin_x[W-1], ray_origin_x};
    dhi     = {phi[W-1], phi} - {ray_origin_x[W-1], ray_origin_x};
    nlo_x   = dlo[W] ? (W+1)'(-dlo) : dlo;
    nhi_x   = dhi[W] ? (W+1)'(-dhi) : dhi;
    neglo_x = dlo[W] ^ ray_dir_x[W-1];
    neghi_x = dhi[W] ^ ray_dir_x[W-1];
    dmag_x  = ray_dir_x[W-1] ? W'(-ray_dir_x) : ray_dir_x;
    // y axis
    plo     = ray_dir_y[W-1] ? box_high_y : box_low_y;
    phi     = ray_dir_y[W-1] ? box_low_y  : box_high_y;
    dlo     = {plo[W-1], plo} - {ray_origin_y[W-1], ray_origin_y};
    dhi     = {phi[W-1], phi} - {ray_origin_y[W-1], ray_origin_y};
    nlo_y   = dlo[W] ? (W+1)'(-dlo) : dlo;
    nhi_y   = dhi[W] ? (W+1)'(-dhi) : dhi;
    neglo_y = dlo[W] ^ ray_dir_y[W-1];
    neghi_y = dhi[W] ^ ray_dir_y[W-1];
    dmag_y  = ray_dir_y[W-1] ? W'(-ray_dir_y) : ray_dir_y;
    // A zero direction sets no limit only if the origin sits inside the slab.
    flags_in.zero_x = ray_dir_x == '0;
    flags_in.zero_y = ray_dir_y == '0;
    flags_in.ok_x   = !flags_in.zero_x ||
                      (box_low_x <= ray_origin_x && ray_origin_x <= box_high_x);
    flags_in.ok_y   = !flags_in.zero_y ||
                      (box_low_y <= ray_origin_y && ray_origin_y <= box_high_y);
  end

  // Setup register feeding the lanes.
  logic [W:0]   r_nlo_x, r_nhi_x, r_nlo_y, r_nhi_y;
  logic [W-1:0] r_dmag_x, r_dmag_y;
  logic         r_neglo_x, r_neghi_x, r_neglo_y, r_neghi_y;

  always_ff @(posedge clk) begin
    if (en) begin
      r_nlo_x   <= nlo_x;
      r_nhi_x   <= nhi_x;
      r_nlo_y   <= nlo_y;
      r_nhi_y   <= nhi_y;
      r_dmag_x  <= dmag_x;
      r_dmag_y  <= dmag_y;
      r_neglo_x <= neglo_x;
      r_neghi_x <= neghi_x;
      r_neglo_y <= neglo_y;
      r_neghi_y <= neghi_y;
    end
  end

  // Valid bits and sideband ride along the lanes; index 0 is the setup register.
  logic                  vld   [0:D];
  rbst_pkg::side_flags_t flg   [0:D];
  logic signed [W-1:0]   wst   [0:D];
  logic signed [W-1:0]   wen   [0:D];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg[0] <= flags_in;
      wst[0] <= window_start;
      wen[0] <= window_end;
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        flg[k+1] <= flg[k];
        wst[k+1] <= wst[k];
        wen[k+1] <= wen[k];
      end
    end
  end

  // Four lanes: entry and exit parameter of each axis slab.
  logic signed [W-1:0] tx_lo, tx_hi, ty_lo, ty_hi;

  rbst_div_lane #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_xlo (
    .clk(clk), .en(en), .num(r_nlo_x), .den(r_dmag_x), .neg(r_neglo_x), .quot(tx_lo)
  );
  rbst_div_lane #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_xhi (
    .clk(clk), .en(en), .num(r_nhi_x), .den(r_dmag_x), .neg(r_neghi_x), .quot(tx_hi)
  );
  rbst_div_lane #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_ylo (
    .clk(clk), .en(en), .num(r_nlo_y), .den(r_dmag_y), .neg(r_neglo_y), .quot(ty_lo)
  );
  rbst_div_lane #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_yhi (
    .clk(clk), .en(en), .num(r_nhi_y), .den(r_dmag_y), .neg(r_neghi_y), .quot(ty_hi)
  );

  // Merge the lanes into the output register.
  rbst_merge #(.WORD_WIDTH(WORD_WIDTH)) u_merge (
    .clk(clk), .en(en), .flags(flg[D]), .win_start(wst[D]), .win_end(wen[D]),
    .tx_lo(tx_lo), .tx_hi(tx_hi), .ty_lo(ty_lo), .ty_hi(ty_hi),
    .hit(hit), .t_enter(t_enter), .t_exit(t_exit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[D];
    end
  end

  // A held pipeline keeps its last stage and its result.
  `ASSERT_NEXT(a_hold_last, clk, rst, vld[D] && !en, vld[D])
  `ASSERT_NEXT(a_hold_out, clk, rst, !en, out_valid)
  `ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid && !vld[0])

endmodule

### sv/rbst_div_lane.sv
// One divider lane: pipelined restoring division with saturation to a signed word.
module rbst_div_lane #(
  parameter int WORD_WIDTH = rbst_pkg::WORD_WIDTH,
  parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [WORD_WIDTH:0]          num,
  input  logic [WORD_WIDTH-1:0]        den,
  input  logic                         neg,
  output logic signed [WORD_WIDTH-1:0] quot
);

  localparam int W = WORD_WIDTH;
  localparam int N = WORD_WIDTH + 1 + FRAC_BITS;

  logic [W:0]   rem  [0:N];
  logic [N-1:0] quo  [0:N];
  logic [W:0]   nums [0:N];
  logic [W-1:0] dens [0:N];
  logic         negs [0:N];

  assign rem[0]  = '0;
  assign quo[0]  = '0;
  assign nums[0] = num;
  assign dens[0] = den;
  assign negs[0] = neg;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic         nbit;
    logic [W:0]   trial;
    logic         ge;
    if (k < W + 1) begin : g_numbit
      assign nbit = nums[k][W-k];
    end else begin : g_zerobit
      assign nbit = 1'b0;
    end
    assign trial = {rem[k][W-1:0], nbit};
    assign ge    = trial >= {1'b0, dens[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? (trial - {1'b0, dens[k]}) : trial;
        quo[k+1]  <= {quo[k][N-2:0], ge};
        nums[k+1] <= nums[k];
        dens[k+1] <= dens[k];
        negs[k+1] <= negs[k];
      end
    end
  end

  // Clamp to the signed range, then apply the sign.
  logic [N-1:0] limit;
  logic [N-1:0] mag_full;
  logic [W-1:0] mag;

  always_comb begin
    limit    = negs[N] ? (N'(1) << (W - 1)) : ((N'(1) << (W - 1)) - N'(1));
    mag_full = (quo[N] > limit) ? limit : quo[N];
    mag      = mag_full[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= negs[N] ? $signed(-mag) : $signed(mag);
    end
  end

endmodule

### sv/rbst_merge.sv
// Merge stage: intersect the two slab intervals and test against the window.
module rbst_merge #(
  parameter int WORD_WIDTH = rbst_pkg::WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         en,
  input  rbst_pkg::side_flags_t        flags,
  input  logic signed [WORD_WIDTH-1:0] win_start,
  input  logic signed [WORD_WIDTH-1:0] win_end,
  input  logic signed [WORD_WIDTH-1:0] tx_lo,
  input  logic signed [WORD_WIDTH-1:0] tx_hi,
  input  logic signed [WORD_WIDTH-1:0] ty_lo,
  input  logic signed [WORD_WIDTH-1:0] ty_hi,
  output logic                         hit,
  output logic signed [WORD_WIDTH-1:0] t_enter,
  output logic signed [WORD_WIDTH-1:0] t_exit
);

  localparam logic signed [WORD_WIDTH-1:0] SMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic signed [WORD_WIDTH-1:0] SMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

  logic signed [WORD_WIDTH-1:0] x0, x1, y0, y1, e, x;
  logic overlap;

  always_comb begin
    x0 = flags.zero_x ? SMIN : tx_lo;
    x1 = flags.zero_x ? SMAX : tx_hi;
    y0 = flags.zero_y ? SMIN : ty_lo;
    y1 = flags.zero_y ? SMAX : ty_hi;
    overlap = flags.ok_x && flags.ok_y && !(x0 > y1) && !(y0 > x1);
    e = (y0 > x0) ? y0 : x0;
    x = (y1 < x1) ? y1 : x1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= overlap && (e < win_end) && (x > win_start);
      t_enter <= overlap ? e : x0;
      t_exit  <= overlap ? x : x1;
    end
  end

endmodule
